// ----- rtl/core/ircpc_pkg.sv -----
// ----------------------------------------------------------------------------
// IR carrier capture package
// Shared constants and the result record of the IR carrier pulse capture.
// ----------------------------------------------------------------------------
package ircpc_pkg;

  localparam int TIMESTAMP_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int TIME_BITS = 32;
  localparam int HZ_BITS = 20;
  localparam int DUTY_BITS = 7;
  localparam int STEP_BITS = $clog2(HZ_BITS + 1);

  localparam logic [HZ_BITS-1:0] HZ_DIVIDEND = 20'd1000000;
  localparam logic [DUTY_BITS-1:0] DUTY_FULL = 7'd100;
  localparam logic [STEP_BITS-1:0] HZ_STEPS = STEP_BITS'(HZ_BITS);
  localparam logic [STEP_BITS-1:0] DUTY_STEPS = STEP_BITS'(DUTY_BITS);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic KIND_CARRIER = 1'b0;
  localparam logic KIND_PAIR = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [DUTY_BITS-1:0] duty_percent;
    logic [HZ_BITS-1:0]   carrier_hz;
    logic [TIME_BITS-1:0] mark_us;
    logic [TIME_BITS-1:0] space_us;
  } res_t;

endpackage

// ----- rtl/core/ircpc_front.sv -----
// ----------------------------------------------------------------------------
// IR carrier capture front end
// Tracks edge timing, measures the carrier period and issues commands.
// ----------------------------------------------------------------------------
module ircpc_front import ircpc_pkg::*; #(
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  operation,
  input  logic                  pin_level,
  input  logic [TIME_BITS-1:0]  time_us,
  output logic                  enq,
  output logic [2*((TIMESTAMP_BITS > TIME_BITS) ? TIMESTAMP_BITS : TIME_BITS):0] entry
);

  localparam int FW = (TIMESTAMP_BITS > TIME_BITS) ? TIMESTAMP_BITS : TIME_BITS;
  localparam int TSB = TIMESTAMP_BITS;

  logic           carrier_started, carrier_started_next;
  logic           carrier_flipped, carrier_flipped_next;
  logic           carrier_done, carrier_done_next;
  logic           first_edge_seen, first_edge_seen_next;
  logic           pair_emitted, pair_emitted_next;
  logic [TSB-1:0] period_start_time, period_start_time_next;
  logic [TSB-1:0] period_flip_time, period_flip_time_next;
  logic [TSB-1:0] carrier_period, carrier_period_next;
  logic [TSB-1:0] last_edge_time, last_edge_time_next;
  logic [TSB-1:0] mark_start_time, mark_start_time_next;

  logic [TSB-1:0]       t;
  logic [TSB-1:0]       gap;
  logic [TSB-1:0]       period_new;
  logic [TSB-1:0]       span;
  logic [TIME_BITS-1:0] pair_mark;
  logic [TIME_BITS-1:0] pair_space;
  logic                 issue;

  assign t = TSB'(time_us);
  assign gap = t - last_edge_time;
  assign period_new = t - period_start_time;
  assign span = period_flip_time - period_start_time;
  assign pair_mark = TIME_BITS'(last_edge_time - mark_start_time);
  assign pair_space = TIME_BITS'(gap);

  always_comb begin
    carrier_started_next = carrier_started;
    carrier_flipped_next = carrier_flipped;
    carrier_done_next = carrier_done;
    first_edge_seen_next = first_edge_seen;
    pair_emitted_next = pair_emitted;
    period_start_time_next = period_start_time;
    period_flip_time_next = period_flip_time;
    carrier_period_next = carrier_period;
    last_edge_time_next = last_edge_time;
    mark_start_time_next = mark_start_time;
    issue = 1'b0;
    entry = {KIND_PAIR, FW'(pair_mark), FW'(pair_space)};
    if (operation == OP_FLUSH) begin
      issue = pair_emitted;
    end else begin
      if (!first_edge_seen) begin
        first_edge_seen_next = 1'b1;
        mark_start_time_next = t;
      end
      if (!carrier_done) begin
        if (!pin_level) begin
          if (!carrier_started) begin
            carrier_started_next = 1'b1;
            period_start_time_next = t;
          end else if (carrier_flipped) begin
            carrier_started_next = 1'b0;
            carrier_flipped_next = 1'b0;
            carrier_done_next = 1'b1;
            carrier_period_next = period_new;
            issue = 1'b1;
            entry = {KIND_CARRIER, FW'(period_new), FW'(span)};
          end
        end else if (carrier_started && !carrier_flipped) begin
          carrier_flipped_next = 1'b1;
          period_flip_time_next = t;
        end
      end else if (gap > carrier_period) begin
        issue = 1'b1;
        mark_start_time_next = t;
        pair_emitted_next = 1'b1;
      end
      last_edge_time_next = t;
    end
  end

  assign enq = accept && issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_started <= 1'b0;
      carrier_flipped <= 1'b0;
      carrier_done <= 1'b0;
      first_edge_seen <= 1'b0;
      pair_emitted <= 1'b0;
    end else if (accept) begin
      carrier_started <= carrier_started_next;
      carrier_flipped <= carrier_flipped_next;
      carrier_done <= carrier_done_next;
      first_edge_seen <= first_edge_seen_next;
      pair_emitted <= pair_emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      period_start_time <= period_start_time_next;
      period_flip_time <= period_flip_time_next;
      carrier_period <= carrier_period_next;
      last_edge_time <= last_edge_time_next;
      mark_start_time <= mark_start_time_next;
    end
  end

endmodule

// ----- rtl/core/ircpc_queue.sv -----
// ----------------------------------------------------------------------------
// IR carrier capture command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module ircpc_queue import ircpc_pkg::*; #(
  parameter int WIDTH = 2 * TIME_BITS + 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full = (count == CNT_BITS'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/core/ircpc_div.sv -----
// ----------------------------------------------------------------------------
// IR carrier capture divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ircpc_div import ircpc_pkg::*; #(
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [TIMESTAMP_BITS-1:0] rem_init,
  input  logic [HZ_BITS-1:0]        bits_init,
  input  logic [STEP_BITS-1:0]      steps,
  input  logic [TIMESTAMP_BITS-1:0] divisor_in,
  output logic                      done,
  output logic [HZ_BITS-1:0]        quot
);

  localparam int TSB = TIMESTAMP_BITS;

  logic [TSB-1:0]       rem;
  logic [TSB-1:0]       divisor;
  logic [HZ_BITS-1:0]   bits;
  logic [STEP_BITS-1:0] cnt;
  logic                 busy;
  logic [TSB:0]         trial;
  logic [TSB:0]         diff;
  logic                 ge;

  assign trial = {rem, bits[HZ_BITS-1]};
  assign diff = trial - {1'b0, divisor};
  assign ge = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      divisor <= divisor_in;
      bits <= bits_init;
      quot <= '0;
    end else if (busy) begin
      rem <= ge ? diff[TSB-1:0] : trial[TSB-1:0];
      bits <= {bits[HZ_BITS-2:0], 1'b0};
      quot <= {quot[HZ_BITS-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/ircpc_back.sv -----
// ----------------------------------------------------------------------------
// IR carrier capture back end
// Turns queued commands into results and holds the result register.
// ----------------------------------------------------------------------------
module ircpc_back import ircpc_pkg::*; #(
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  logic [2*((TIMESTAMP_BITS > TIME_BITS) ? TIMESTAMP_BITS : TIME_BITS):0] q_data,
  output logic   q_pop,
  input  logic   pop,
  output logic   empty,
  output res_t   res
);

  localparam int FW = (TIMESTAMP_BITS > TIME_BITS) ? TIMESTAMP_BITS : TIME_BITS;
  localparam int TSB = TIMESTAMP_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HZ = 2'd1;
  localparam logic [1:0] ST_DUTY = 2'd2;

  logic [1:0]             state;
  logic                   res_valid;
  logic [TSB-1:0]         period;
  logic [TSB-1:0]         span;
  logic                   e_kind;
  logic [FW-1:0]          e_a;
  logic [FW-1:0]          e_b;
  logic [TSB-1:0]         e_period;
  logic [TSB+DUTY_BITS-1:0] span_wide;
  logic [TSB+DUTY_BITS-1:0] product;
  logic                   span_full;
  logic                   div_start;
  logic [TSB-1:0]         div_rem;
  logic [HZ_BITS-1:0]     div_bits;
  logic [STEP_BITS-1:0]   div_steps;
  logic [TSB-1:0]         div_divisor;
  logic                   div_done;
  logic [HZ_BITS-1:0]     div_quot;

  assign e_kind = q_data[2*FW];
  assign e_a = q_data[2*FW-1:FW];
  assign e_b = q_data[FW-1:0];
  assign e_period = e_a[TSB-1:0];

  assign span_wide = {{DUTY_BITS{1'b0}}, span};
  assign product = (span_wide << 6) + (span_wide << 5) + (span_wide << 2);
  assign span_full = (span >= period);

  assign empty = !res_valid;
  assign q_pop = (state == ST_IDLE) && !res_valid && !q_empty;

  always_comb begin
    if (state == ST_IDLE) begin
      div_rem = '0;
      div_bits = HZ_DIVIDEND;
      div_steps = HZ_STEPS;
      div_divisor = e_period;
      div_start = q_pop && (e_kind == KIND_CARRIER) && (e_period != '0);
    end else begin
      div_rem = product[TSB+DUTY_BITS-1:DUTY_BITS];
      div_bits = {product[DUTY_BITS-1:0], {(HZ_BITS - DUTY_BITS){1'b0}}};
      div_steps = DUTY_STEPS;
      div_divisor = period;
      div_start = (state == ST_HZ) && div_done && !span_full;
    end
  end

  ircpc_div #(
    .TIMESTAMP_BITS(TIMESTAMP_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .rem_init  (div_rem),
    .bits_init (div_bits),
    .steps     (div_steps),
    .divisor_in(div_divisor),
    .done      (div_done),
    .quot      (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (e_kind == KIND_PAIR || e_period == '0) begin
              res_valid <= 1'b1;
            end else begin
              state <= ST_HZ;
            end
          end
        end
        ST_HZ: begin
          if (div_done) begin
            if (span_full) begin
              res_valid <= 1'b1;
              state <= ST_IDLE;
            end else begin
              state <= ST_DUTY;
            end
          end
        end
        ST_DUTY: begin
          if (div_done) begin
            res_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          period <= e_period;
          span <= e_b[TSB-1:0];
          res.kind <= e_kind;
          res.duty_percent <= '0;
          res.carrier_hz <= '0;
          if (e_kind == KIND_PAIR) begin
            res.mark_us <= e_a[TIME_BITS-1:0];
            res.space_us <= e_b[TIME_BITS-1:0];
          end else begin
            res.mark_us <= '0;
            res.space_us <= '0;
          end
        end
      end
      ST_HZ: begin
        if (div_done) begin
          res.carrier_hz <= div_quot;
          if (span_full) begin
            res.duty_percent <= DUTY_FULL;
          end
        end
      end
      ST_DUTY: begin
        if (div_done) begin
          res.duty_percent <= div_quot[DUTY_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/ir_carrier_pulse_capture.sv -----
// ----------------------------------------------------------------------------
// IR carrier pulse capture
// Measures the carrier of an inverted IR receiver pin and reports mark/space
// pairs from timestamped edge events.
//
// Channel   Direction  Handshake         Payload
// input     in         push / full       operation, pin_level, time_us
// result    out        empty / pop       kind, duty_percent, carrier_hz,
//                                        mark_us, space_us
//
// Edge and flush items are taken one per cycle while the command queue has
// room. A mark/space pair, and a carrier result with a zero period, passes
// through the command queue and is then written straight into the result
// register. Any other carrier measurement runs through the shared iterative
// divider, which yields one quotient bit per cycle: first the 20-bit frequency
// and then, unless the duty cycle saturates, the 7-bit duty cycle. Reset is
// synchronous and needs no clearing pass. A stalled result does not stop input
// transfers until the queue fills.
// ----------------------------------------------------------------------------
module ir_carrier_pulse_capture import ircpc_pkg::*; #(
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 operation,
  input  logic                 pin_level,
  input  logic [TIME_BITS-1:0] time_us,
  output logic                 empty,
  input  logic                 pop,
  output logic                 kind,
  output logic [DUTY_BITS-1:0] duty_percent,
  output logic [HZ_BITS-1:0]   carrier_hz,
  output logic [TIME_BITS-1:0] mark_us,
  output logic [TIME_BITS-1:0] space_us
);

  localparam int FW = (TIMESTAMP_BITS > TIME_BITS) ? TIMESTAMP_BITS : TIME_BITS;
  localparam int ENTRY_BITS = 2 * FW + 1;

  logic                  accept;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [ENTRY_BITS-1:0] q_wdata;
  logic [ENTRY_BITS-1:0] q_rdata;
  res_t                  res;

  assign full = q_full;
  assign accept = push && !q_full;

  ircpc_front #(
    .TIMESTAMP_BITS(TIMESTAMP_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .operation(operation),
    .pin_level(pin_level),
    .time_us  (time_us),
    .enq      (q_push),
    .entry    (q_wdata)
  );

  ircpc_queue #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  ircpc_back #(
    .TIMESTAMP_BITS(TIMESTAMP_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .res    (res)
  );

  assign kind = res.kind;
  assign duty_percent = res.duty_percent;
  assign carrier_hz = res.carrier_hz;
  assign mark_us = res.mark_us;
  assign space_us = res.space_us;

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("Command written into a full queue.");
  a_pop_has_entry: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("Command taken from an empty queue.");
  a_pop_result_free: assert property (@(posedge clk) disable iff (rst) q_pop |-> empty)
    else $error("Command taken while a result still waits.");
`endif

endmodule
